// ----- rtl/jsu_pkg.sv -----
package jsu_pkg;

   // Most bytes that one input byte can produce
   localparam int MaxResults = 8;
   localparam int CountWidth = $clog2(MaxResults + 1);
   localparam int IdxWidth   = $clog2(MaxResults);

   // One raw input byte as held in the input registers
   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } item_type;

   // Output bytes produced by one input byte, loaded into the output stage at once
   typedef struct packed {
      logic [MaxResults-1:0][7:0] data;
      logic [CountWidth-1:0]      count;
      logic                       fin;
      logic                       marker;
   } burst_type;

endpackage

// ----- rtl/jsu_in_skid.sv -----
module jsu_in_skid (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_in_byte,
   input  logic               req_end_of_string,
   input  logic               take,
   output logic               item_valid,
   output jsu_pkg::item_type  item
);
   import jsu_pkg::*;

   item_type main_ff, main_in;
   item_type skid_ff, skid_in;
   logic     main_valid_ff, main_valid_in;
   logic     skid_valid_ff, skid_valid_in;
   item_type req_item;
   logic     accept;

   // Stall only from a register: the spare entry is full
   assign req_stall  = skid_valid_ff;
   assign accept     = req_valid && !skid_valid_ff;
   assign req_item   = '{in_byte: req_in_byte, end_of_string: req_end_of_string};
   assign item_valid = main_valid_ff;
   assign item       = main_ff;

   // Main entry feeds the decoder, spare entry catches a transfer while main waits
   always_comb begin
      main_in       = main_ff;
      skid_in       = skid_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            main_in = req_item;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (main_valid_ff) begin
            skid_in       = req_item;
            skid_valid_in = 1'b1;
         end else begin
            main_in       = req_item;
            main_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   // Spare entry is only ever used behind a full main entry
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("spare entry full while main entry empty");

   // A waiting spare entry moves up as soon as the main entry is taken
   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && take) |=> (main_valid_ff && !skid_valid_ff))
      else $error("spare entry did not move into main entry");

endmodule

// ----- rtl/jsu_decode.sv -----
module jsu_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  jsu_pkg::item_type   item,
   input  logic                can_load,
   output logic                take,
   output jsu_pkg::burst_type  burst
);
   import jsu_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_BSL,
      PH_UHEX,
      PH_XHEX,
      PH_OCT
   } phase_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      len;
   } seg_type;

   typedef struct packed {
      logic [MaxResults-1:0][7:0] data;
      logic [CountWidth-1:0]      count;
   } acc_type;

   // Character codes
   localparam logic [7:0] ChBackslash = 8'h5C;
   localparam logic [7:0] ChB         = 8'h62;
   localparam logic [7:0] ChF         = 8'h66;
   localparam logic [7:0] ChN         = 8'h6E;
   localparam logic [7:0] ChR         = 8'h72;
   localparam logic [7:0] ChT         = 8'h74;
   localparam logic [7:0] ChU         = 8'h75;
   localparam logic [7:0] ChX         = 8'h78;
   localparam logic [7:0] Ch0         = 8'h30;
   localparam logic [7:0] Ch7         = 8'h37;
   localparam logic [7:0] Ch9         = 8'h39;
   localparam logic [7:0] ChUpA       = 8'h41;
   localparam logic [7:0] ChUpF       = 8'h46;
   localparam logic [7:0] ChLoA       = 8'h61;
   localparam logic [7:0] ChLoF       = 8'h66;
   localparam logic [7:0] CtlBs       = 8'd8;
   localparam logic [7:0] CtlTab      = 8'd9;
   localparam logic [7:0] CtlLf       = 8'd10;
   localparam logic [7:0] CtlFf       = 8'd12;
   localparam logic [7:0] CtlCr       = 8'd13;

   // UTF-8 lead and continuation marks
   localparam logic [7:0] Lead2  = 8'd192;
   localparam logic [7:0] Lead3  = 8'd224;
   localparam logic [7:0] Lead4  = 8'd240;
   localparam logic [7:0] ContMk = 8'd128;

   // Surrogate ranges and supplementary-plane offset
   localparam logic [15:0] HighLo   = 16'hD800;
   localparam logic [15:0] HighHi   = 16'hDBFF;
   localparam logic [15:0] LowLo    = 16'hDC00;
   localparam logic [15:0] LowHi    = 16'hDFFF;
   localparam logic [20:0] SuppBase = 21'h10000;

   localparam logic [2:0] LastHexDigit = 3'd3;

   // {valid, value} of a hex digit
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= Ch0 && c <= Ch9) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= ChUpA && c <= ChUpF) || (c >= ChLoA && c <= ChLoF)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   function automatic seg_type one_byte(input logic [7:0] b);
      seg_type s;
      s          = '0;
      s.bytes[0] = b;
      s.len      = 3'd1;
      return s;
   endfunction

   function automatic seg_type utf8(input logic [20:0] cp);
      seg_type s;
      s = '0;
      if (cp <= 21'd127) begin
         s.bytes[0] = cp[7:0];
         s.len      = 3'd1;
      end else if (cp <= 21'd2047) begin
         s.bytes[0] = Lead2 | {3'b000, cp[10:6]};
         s.bytes[1] = ContMk | {2'b00, cp[5:0]};
         s.len      = 3'd2;
      end else if (cp <= 21'd65535) begin
         s.bytes[0] = Lead3 | {4'b0000, cp[15:12]};
         s.bytes[1] = ContMk | {2'b00, cp[11:6]};
         s.bytes[2] = ContMk | {2'b00, cp[5:0]};
         s.len      = 3'd3;
      end else begin
         s.bytes[0] = Lead4 | {5'b00000, cp[20:18]};
         s.bytes[1] = ContMk | {2'b00, cp[17:12]};
         s.bytes[2] = ContMk | {2'b00, cp[11:6]};
         s.bytes[3] = ContMk | {2'b00, cp[5:0]};
         s.len      = 3'd4;
      end
      return s;
   endfunction

   // Plain-text replay of a partial escape: letter (hex escapes only), then collected digits
   function automatic seg_type dump(input phase_type ph, input logic [2:0] dc,
                                    input logic [3:0][7:0] raw);
      seg_type s;
      s = '0;
      case (ph) inside
         PH_UHEX, PH_XHEX: begin
            s.bytes[0]   = (ph == PH_UHEX) ? ChU : ChX;
            s.bytes[3:1] = raw[2:0];
            s.len        = dc + 3'd1;
         end
         PH_OCT: begin
            s.bytes = raw;
            s.len   = dc;
         end
         default: ;
      endcase
      return s;
   endfunction

   function automatic acc_type push(input acc_type a, input seg_type s);
      acc_type r;
      r = a;
      for (int i = 0; i < 4; i++) begin
         if (3'(i) < s.len && r.count < CountWidth'(MaxResults)) begin
            r.data[r.count[IdxWidth-1:0]] = s.bytes[i];
            r.count = r.count + CountWidth'(1);
         end
      end
      return r;
   endfunction

   phase_type       ph_ff, ph_in;
   logic [2:0]      dc_ff, dc_in;
   logic [15:0]     cu_ff, cu_in;
   logic [3:0][7:0] raw_ff, raw_in;
   logic [15:0]     held_ff, held_in;
   logic            hv_ff, hv_in;

   logic [7:0]      b;
   logic [4:0]      hex;
   logic            is_oct;
   logic [15:0]     unit_next;
   logic [20:0]     pair_cp;
   logic            rel;
   logic            dump_old;
   logic            plain;
   seg_type         main_seg;
   acc_type         acc;

   assign take = item_valid && can_load;

   // Next escape state and the segments this byte emits
   always_comb begin
      b         = item.in_byte;
      hex       = hex_digit(b);
      is_oct    = (b >= Ch0) && (b <= Ch7);
      unit_next = {cu_ff[11:0], hex[3:0]};
      pair_cp   = {1'b0, held_ff[9:0], unit_next[9:0]} + SuppBase;

      ph_in    = ph_ff;
      dc_in    = dc_ff;
      cu_in    = cu_ff;
      raw_in   = raw_ff;
      held_in  = held_ff;
      hv_in    = hv_ff;
      rel      = 1'b0;
      dump_old = 1'b0;
      plain    = 1'b0;
      main_seg = '0;

      unique case (ph_ff)
         PH_BSL: begin
            ph_in = PH_IDLE;
            if (b != ChU) begin
               rel     = hv_ff;
               hv_in   = 1'b0;
               held_in = '0;
            end
            case (b)
               ChB: main_seg = one_byte(CtlBs);
               ChF: main_seg = one_byte(CtlFf);
               ChN: main_seg = one_byte(CtlLf);
               ChR: main_seg = one_byte(CtlCr);
               ChT: main_seg = one_byte(CtlTab);
               ChU: begin
                  ph_in = PH_UHEX;
                  dc_in = '0;
                  cu_in = '0;
               end
               ChX: begin
                  ph_in = PH_XHEX;
                  dc_in = '0;
                  cu_in = '0;
               end
               default: begin
                  if (is_oct) begin
                     ph_in     = PH_OCT;
                     raw_in[0] = b;
                     dc_in     = 3'd1;
                     cu_in     = '0;
                  end else begin
                     main_seg = one_byte(b);
                  end
               end
            endcase
         end
         PH_UHEX: begin
            if (hex[4]) begin
               raw_in[dc_ff[1:0]] = b;
               cu_in              = unit_next;
               if (dc_ff == LastHexDigit) begin
                  ph_in = PH_IDLE;
                  dc_in = '0;
                  if (hv_ff && unit_next >= LowLo && unit_next <= LowHi) begin
                     // high and low halves combine into one code point
                     main_seg = utf8(pair_cp);
                     hv_in    = 1'b0;
                     held_in  = '0;
                  end else begin
                     rel     = hv_ff;
                     hv_in   = 1'b0;
                     held_in = '0;
                     if (unit_next >= HighLo && unit_next <= HighHi) begin
                        held_in = unit_next;
                        hv_in   = 1'b1;
                     end else begin
                        main_seg = utf8({5'b00000, unit_next});
                     end
                  end
               end else begin
                  dc_in = dc_ff + 3'd1;
               end
            end else begin
               rel      = hv_ff;
               hv_in    = 1'b0;
               held_in  = '0;
               dump_old = 1'b1;
               ph_in    = PH_IDLE;
               dc_in    = '0;
               cu_in    = '0;
               plain    = 1'b1;
            end
         end
         PH_XHEX: begin
            if (hex[4]) begin
               if (dc_ff == '0) begin
                  raw_in[0] = b;
                  cu_in     = {12'h000, hex[3:0]};
                  dc_in     = 3'd1;
               end else begin
                  main_seg = one_byte({cu_ff[3:0], hex[3:0]});
                  ph_in    = PH_IDLE;
                  dc_in    = '0;
                  cu_in    = '0;
               end
            end else begin
               dump_old = 1'b1;
               ph_in    = PH_IDLE;
               dc_in    = '0;
               cu_in    = '0;
               plain    = 1'b1;
            end
         end
         PH_OCT: begin
            if (is_oct) begin
               main_seg = one_byte({2'b00, raw_ff[0][2:0], b[2:0]});
            end else begin
               dump_old = 1'b1;
               plain    = 1'b1;
            end
            ph_in = PH_IDLE;
            dc_in = '0;
            cu_in = '0;
         end
         default: begin
            ph_in = PH_IDLE;
            plain = 1'b1;
         end
      endcase

      // Byte handled as ordinary text
      if (plain) begin
         if (b == ChBackslash) begin
            ph_in = PH_BSL;
         end else begin
            rel      = rel | hv_ff;
            hv_in    = 1'b0;
            held_in  = '0;
            main_seg = one_byte(b);
         end
      end
   end

   // Output order: released surrogate, replayed escape, decoded bytes, end flush
   always_comb begin
      acc = '0;
      if (rel) begin
         acc = push(acc, utf8({5'b00000, held_ff}));
      end
      if (dump_old) begin
         acc = push(acc, dump(ph_ff, dc_ff, raw_ff));
      end
      acc = push(acc, main_seg);
      if (item.end_of_string) begin
         if (hv_in) begin
            acc = push(acc, utf8({5'b00000, held_in}));
         end
         acc = push(acc, dump(ph_in, dc_in, raw_in));
      end

      burst.data   = acc.data;
      burst.count  = acc.count;
      burst.fin    = item.end_of_string;
      burst.marker = 1'b0;
      // Empty end of string still reports once
      if (item.end_of_string && acc.count == '0) begin
         burst.data   = '0;
         burst.count  = CountWidth'(1);
         burst.marker = 1'b1;
      end
   end

   // Escape state; end of string returns everything to idle
   always_ff @(posedge clock) begin
      if (take) begin
         raw_ff <= raw_in;
      end
      if (reset) begin
         ph_ff   <= PH_IDLE;
         dc_ff   <= '0;
         cu_ff   <= '0;
         held_ff <= '0;
         hv_ff   <= 1'b0;
      end else if (take) begin
         if (item.end_of_string) begin
            ph_ff   <= PH_IDLE;
            dc_ff   <= '0;
            cu_ff   <= '0;
            held_ff <= '0;
            hv_ff   <= 1'b0;
         end else begin
            ph_ff   <= ph_in;
            dc_ff   <= dc_in;
            cu_ff   <= cu_in;
            held_ff <= held_in;
            hv_ff   <= hv_in;
         end
      end
   end

   // A held surrogate waits only in idle, after a backslash or in the \u hex collector
   a_held_phase: assert property (@(posedge clock) disable iff (reset)
      hv_ff |-> (ph_ff == PH_IDLE || ph_ff == PH_BSL || ph_ff == PH_UHEX))
      else $error("surrogate held during hex or octal escape");

   // Held value is always a high surrogate
   a_held_range: assert property (@(posedge clock) disable iff (reset)
      hv_ff |-> (held_ff >= HighLo && held_ff <= HighHi))
      else $error("held unit is not a high surrogate");

   // Digit count stays inside each collector's range
   a_digit_count: assert property (@(posedge clock) disable iff (reset)
      (ph_ff == PH_UHEX |-> dc_ff <= LastHexDigit) and
      (ph_ff == PH_XHEX |-> dc_ff <= 3'd1) and
      (ph_ff == PH_OCT |-> dc_ff == 3'd1))
      else $error("digit count out of range");

   // End of string leaves no escape or surrogate pending
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (take && item.end_of_string) |=> (ph_ff == PH_IDLE && !hv_ff && dc_ff == '0))
      else $error("state not cleared after end of string");

endmodule

// ----- rtl/jsu_out_burst.sv -----
module jsu_out_burst (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  jsu_pkg::burst_type  burst,
   output logic                can_load,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_byte_valid,
   output logic                rsp_last_of_run,
   output logic                rsp_string_done
);
   import jsu_pkg::*;

   logic [MaxResults-1:0][7:0] data_ff, data_in;
   logic [CountWidth-1:0]      cnt_ff, cnt_in;
   logic                       fin_ff, fin_in;
   logic                       marker_ff, marker_in;
   logic                       pop;
   logic                       last;

   assign last      = (cnt_ff == CountWidth'(1));
   assign pop       = rsp_valid && !rsp_stall;
   // Room for a new run once the current one is gone or leaving now
   assign can_load  = (cnt_ff == '0) || (last && !rsp_stall);

   assign rsp_valid       = (cnt_ff != '0);
   assign rsp_out_byte    = data_ff[0];
   assign rsp_byte_valid  = !marker_ff;
   assign rsp_last_of_run = last;
   assign rsp_string_done = last && fin_ff;

   // Load a whole run, then shift one byte out per transfer
   always_comb begin
      data_in   = data_ff;
      cnt_in    = cnt_ff;
      fin_in    = fin_ff;
      marker_in = marker_ff;
      if (load) begin
         data_in   = burst.data;
         cnt_in    = burst.count;
         fin_in    = burst.fin;
         marker_in = burst.marker;
      end else if (pop) begin
         data_in = {8'h00, data_ff[MaxResults-1:1]};
         cnt_in  = cnt_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      data_ff   <= data_in;
      fin_ff    <= fin_in;
      marker_ff <= marker_in;
   end

   // A load never drops bytes still waiting
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (cnt_ff == '0 || (last && pop)))
      else $error("run loaded over pending bytes");

   // Each transfer without a load removes exactly one byte
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (pop && !load) |=> (cnt_ff == $past(cnt_ff) - CountWidth'(1)))
      else $error("byte count did not step down");

   // The empty end marker is always a run of its own that ends the string
   a_marker_alone: assert property (@(posedge clock) disable iff (reset)
      (marker_ff && rsp_valid) |-> (last && fin_ff))
      else $error("empty marker inside a longer run");

endmodule

// ----- rtl/json_string_unescape_utf8.sv -----
// JSON string body unescaper with UTF-8 output.
// Input channel (req_*): one raw byte of the escaped string body per transfer,
// with req_end_of_string set on the final byte of the string.
// Result channel (rsp_*): decoded bytes, one per transfer. An input byte makes
// zero to eight results; rsp_last_of_run marks the last one it made, and
// rsp_string_done the last one of the string. A string that ends with nothing
// left to report gives one result with rsp_byte_valid low.
// An accepted byte passes through the input buffer's main entry and then the
// output stage register on its way to the rsp side. Throughput: one input byte per
// cycle while each byte makes at most one result and rsp_stall stays low; a byte
// that expands to several bytes holds the output stage until all have left by the
// single output port, and the two-entry input buffer takes up to two more bytes
// during that time before req_stall rises. A stalled rsp side holds its byte; once
// the input buffer is full, req_stall rises. Reset (synchronous) empties both
// buffers and drops any pending escape and held surrogate.
module json_string_unescape_utf8 (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_string,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_last_of_run,
   output logic       rsp_string_done
);
   import jsu_pkg::*;

   item_type  item;
   logic      item_valid;
   logic      take;
   logic      can_load;
   burst_type burst;

   jsu_in_skid u_in_skid (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .take              (take),
      .item_valid        (item_valid),
      .item              (item)
   );

   jsu_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .can_load   (can_load),
      .take       (take),
      .burst      (burst)
   );

   jsu_out_burst u_out_burst (
      .clock           (clock),
      .reset           (reset),
      .load            (take),
      .burst           (burst),
      .can_load        (can_load),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_string_done (rsp_string_done)
   );

endmodule

// ----- tb/sv/json_string_unescape_utf8_tb.sv -----
module json_string_unescape_utf8_tb;

   localparam int          CycleLimit = 200000;
   localparam int          HoldLen    = 150;
   localparam logic [7:0]  Backslash  = 8'h5C;
   localparam logic [39:0] EscLetters = "bfnrt";

   // escape decoder phases
   typedef enum logic [2:0] {
      PH_IDLE, PH_BSL, PH_UHEX, PH_XHEX, PH_OCT
   } esc_phase_type;

   // pacing of the two channels
   typedef enum logic [1:0] {
      MODE_SLOW_RX, MODE_SLOW_TX, MODE_PRESSURE, MODE_FREE
   } pace_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       last_of_run;
      logic       string_done;
   } rsp_type;

   // directed row; typed rows carry their single result
   typedef struct packed {
      logic [7:0] in_byte;
      logic       eos;
      logic       typed;
      logic [7:0] want_byte;
      logic       want_valid;
   } dir_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_end_of_string = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_last_of_run;
   logic       rsp_string_done;

   pace_type    pace = MODE_SLOW_RX;
   int unsigned tx_pct [4] = '{22, 86, 0, 0};
   int unsigned rx_pct [4] = '{86, 22, 0, 0};
   int          phase_items [4] = '{115, 115, 40, 113};
   int          errors = 0;
   int          cycle_count = 0;
   int          hold_cycles = 0;

   jsu_pkg::item_type stim_q [$];
   rsp_type           due_bytes [$];
   logic [7:0]        run_bytes [$];
   rsp_type           got, want;

   // decoder copy
   esc_phase_type ph = PH_IDLE;
   logic [2:0]  ndig = '0;
   logic [15:0] unit = '0;
   logic [7:0]  digs [4];
   logic [15:0] held_hi = '0;
   logic        held = 1'b0;

   dir_row_type dir_tab [27] = '{
      '{8'h41, 1'b1, 1'b1, 8'h41, 1'b1},      // plain byte ending a string
      '{8'h00, 1'b0, 1'b1, 8'h00, 1'b1},
      '{8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1},
      '{Backslash, 1'b1, 1'b1, 8'h00, 1'b0},  // lone backslash: empty end marker
      '{Backslash, 1'b0, 1'b0, 8'h00, 1'b0},
      '{"t", 1'b0, 1'b1, 8'h09, 1'b1},
      '{Backslash, 1'b0, 1'b0, 8'h00, 1'b0},  // surrogate pair
      '{"u", 1'b0, 1'b0, 8'h00, 1'b0},
      '{"D", 1'b0, 1'b0, 8'h00, 1'b0},
      '{"8", 1'b0, 1'b0, 8'h00, 1'b0},
      '{"3", 1'b0, 1'b0, 8'h00, 1'b0},
      '{"D", 1'b0, 1'b0, 8'h00, 1'b0},
      '{Backslash, 1'b0, 1'b0, 8'h00, 1'b0},
      '{"u", 1'b0, 1'b0, 8'h00, 1'b0},
      '{"d", 1'b0, 1'b0, 8'h00, 1'b0},
      '{"e", 1'b0, 1'b0, 8'h00, 1'b0},
      '{"0", 1'b0, 1'b0, 8'h00, 1'b0},
      '{"0", 1'b0, 1'b0, 8'h00, 1'b0},
      '{Backslash, 1'b0, 1'b0, 8'h00, 1'b0},  // largest octal escape
      '{"7", 1'b0, 1'b0, 8'h00, 1'b0},
      '{"7", 1'b0, 1'b1, 8'h3F, 1'b1},
      '{Backslash, 1'b0, 1'b0, 8'h00, 1'b0},  // malformed hex escape
      '{"x", 1'b0, 1'b0, 8'h00, 1'b0},
      '{"g", 1'b0, 1'b0, 8'h00, 1'b0},
      '{Backslash, 1'b0, 1'b0, 8'h00, 1'b0},  // partial hex escape at end
      '{"x", 1'b0, 1'b0, 8'h00, 1'b0},
      '{"4", 1'b1, 1'b0, 8'h00, 1'b0}
   };

   json_string_unescape_utf8 uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_string_done   (rsp_string_done)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Decoder prediction
   // ---------------------------------------------------------------

   function automatic int hex_val(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - 48;
      if (c >= "A" && c <= "F") return int'(c) - 55;
      if (c >= "a" && c <= "f") return int'(c) - 87;
      return -1;
   endfunction

   task put_out(input logic [7:0] b);
      if (run_bytes.size() < jsu_pkg::MaxResults) run_bytes.push_back(b);
   endtask

   task emit_utf8(input logic [20:0] cp);
      if (cp <= 21'd127) begin
         put_out(cp[7:0]);
      end else if (cp <= 21'd2047) begin
         put_out(8'hC0 | {3'b000, cp[10:6]});
         put_out(8'h80 | {2'b00, cp[5:0]});
      end else if (cp <= 21'd65535) begin
         put_out(8'hE0 | {4'h0, cp[15:12]});
         put_out(8'h80 | {2'b00, cp[11:6]});
         put_out(8'h80 | {2'b00, cp[5:0]});
      end else begin
         put_out(8'hF0 | {5'b00000, cp[20:18]});
         put_out(8'h80 | {2'b00, cp[17:12]});
         put_out(8'h80 | {2'b00, cp[11:6]});
         put_out(8'h80 | {2'b00, cp[5:0]});
      end
   endtask

   task release_surrogate();
      if (held) begin
         emit_utf8({5'b00000, held_hi});
         held    = 1'b0;
         held_hi = '0;
      end
   endtask

   // high surrogates wait for a partner, everything else goes out
   task keep_unit(input logic [15:0] u);
      if (u >= 16'hD800 && u <= 16'hDBFF) begin
         held_hi = u;
         held    = 1'b1;
      end else begin
         emit_utf8({5'b00000, u});
      end
   endtask

   task put_digits();
      for (int i = 0; i < ndig && i < 4; i++) put_out(digs[i]);
   endtask

   task start_digits(input esc_phase_type p);
      ph   = p;
      ndig = '0;
      unit = '0;
   endtask

   task take_plain(input logic [7:0] b);
      if (b == Backslash) begin
         ph = PH_BSL;
      end else begin
         release_surrogate();
         put_out(b);
      end
   endtask

   task clear_decoder();
      ph      = PH_IDLE;
      ndig    = '0;
      unit    = '0;
      held_hi = '0;
      held    = 1'b0;
      for (int i = 0; i < 4; i++) digs[i] = '0;
   endtask

   task decode_step(input logic [7:0] b);
      int v;
      case (ph)
         PH_BSL: begin
            if (b != "u") release_surrogate();
            ph = PH_IDLE;
            case (b)
               "b": put_out(8'h08);
               "f": put_out(8'h0C);
               "n": put_out(8'h0A);
               "r": put_out(8'h0D);
               "t": put_out(8'h09);
               "u": start_digits(PH_UHEX);
               "x": start_digits(PH_XHEX);
               default: begin
                  if (b >= "0" && b <= "7") begin
                     start_digits(PH_OCT);
                     digs[0] = b;
                     ndig    = 3'd1;
                  end else begin
                     put_out(b);
                  end
               end
            endcase
         end
         PH_UHEX: begin
            v = hex_val(b);
            if (v >= 0 && ndig < 3'd4) begin
               digs[ndig[1:0]] = b;
               unit = {unit[11:0], 4'(v)};
               ndig = ndig + 3'd1;
               if (ndig >= 3'd4) begin
                  ph   = PH_IDLE;
                  ndig = '0;
                  // a low unit right after a held high unit joins it
                  if (held && unit >= 16'hDC00 && unit <= 16'hDFFF) begin
                     emit_utf8(21'h10000 + 21'({held_hi[9:0], unit[9:0]}));
                     held    = 1'b0;
                     held_hi = '0;
                  end else begin
                     release_surrogate();
                     keep_unit(unit);
                  end
               end
            end else begin
               release_surrogate();
               put_out("u");
               put_digits();
               start_digits(PH_IDLE);
               take_plain(b);
            end
         end
         PH_XHEX: begin
            v = hex_val(b);
            if (v >= 0) begin
               if (ndig == 3'd0) begin
                  digs[0] = b;
                  unit    = 16'(v);
                  ndig    = 3'd1;
               end else begin
                  put_out({unit[3:0], 4'(v)});
                  start_digits(PH_IDLE);
               end
            end else begin
               put_out("x");
               put_digits();
               start_digits(PH_IDLE);
               take_plain(b);
            end
         end
         PH_OCT: begin
            if (b >= "0" && b <= "7") begin
               put_out({2'b00, digs[0][2:0], b[2:0]});
               start_digits(PH_IDLE);
            end else begin
               put_out(digs[0]);
               start_digits(PH_IDLE);
               take_plain(b);
            end
         end
         default: begin
            ph = PH_IDLE;
            take_plain(b);
         end
      endcase
   endtask

   // one input byte: decode, then flush everything pending at end of string
   task unescape_byte(input logic [7:0] b, input logic fin);
      run_bytes.delete();
      decode_step(b);
      if (fin) begin
         release_surrogate();
         case (ph)
            PH_UHEX: begin
               put_out("u");
               put_digits();
            end
            PH_XHEX: begin
               put_out("x");
               put_digits();
            end
            PH_OCT: put_out(digs[0]);
            default: ;
         endcase
         clear_decoder();
      end
   endtask

   task queue_run(input logic fin);
      if (run_bytes.size() == 0) begin
         if (fin) due_bytes.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
      end else begin
         for (int k = 0; k < run_bytes.size(); k++)
            due_bytes.push_back('{run_bytes[k], 1'b1, k == run_bytes.size() - 1,
                                  (k == run_bytes.size() - 1) && fin});
      end
   endtask

   // ---------------------------------------------------------------
   // Random stimulus
   // ---------------------------------------------------------------

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) return 8'h30 + {4'h0, nib};
      return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'h0, nib} - 8'd10;
   endfunction

   task push_stim(input logic [7:0] b);
      stim_q.push_back('{in_byte: b, end_of_string: 1'b0});
   endtask

   task push_unit(input logic [15:0] u);
      push_stim(Backslash);
      push_stim("u");
      for (int s = 3; s >= 0; s--) push_stim(hex_char(u[s*4 +: 4]));
   endtask

   // plain bytes and mostly well-formed escapes with random content, some broken ones
   task add_token();
      int unsigned pick, k;
      logic [15:0] u;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         push_stim(8'($urandom_range(0, 255)));
      end else if (pick < 35) begin
         push_stim(Backslash);
         k = $urandom_range(0, 5);
         push_stim(k < 5 ? EscLetters[k*8 +: 8] : 8'($urandom_range(0, 255)));
      end else if (pick < 55) begin
         case ($urandom_range(0, 4))
            0: u = 16'($urandom);
            1: u = 16'($urandom_range(0, 16'h7F));
            2: u = 16'($urandom_range(16'h80, 16'h7FF));
            3: u = 16'($urandom_range(16'hD800, 16'hDBFF));
            default: u = 16'($urandom_range(16'hDC00, 16'hDFFF));
         endcase
         push_unit(u);
      end else if (pick < 68) begin
         push_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
         push_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
      end else if (pick < 76) begin
         push_stim(Backslash);
         push_stim("x");
         push_stim(hex_char(4'($urandom)));
         push_stim(hex_char(4'($urandom)));
      end else if (pick < 84) begin
         push_stim(Backslash);
         push_stim(8'h30 + 8'($urandom_range(0, 7)));
         push_stim(8'h30 + 8'($urandom_range(0, 7)));
      end else if (pick < 94) begin
         // escape cut short by a stray byte or by the end of the string
         push_stim(Backslash);
         case ($urandom_range(0, 2))
            0: begin
               push_stim("u");
               k = $urandom_range(0, 3);
               for (int i = 0; i < k; i++) push_stim(hex_char(4'($urandom)));
            end
            1: begin
               push_stim("x");
               if ($urandom_range(0, 1)) push_stim(hex_char(4'($urandom)));
            end
            default: push_stim(8'h30 + 8'($urandom_range(0, 7)));
         endcase
         if ($urandom_range(0, 1)) stim_q[stim_q.size() - 1].end_of_string = 1'b1;
         else push_stim(8'($urandom_range(0, 255)));
      end else begin
         // high surrogate with no partner
         push_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
         if ($urandom_range(0, 1)) begin
            push_stim(8'($urandom_range(0, 255)));
         end else begin
            push_stim(Backslash);
            push_stim(EscLetters[$urandom_range(0, 4)*8 +: 8]);
         end
      end
      if ($urandom_range(0, 9) == 0) stim_q[stim_q.size() - 1].end_of_string = 1'b1;
   endtask

   // ---------------------------------------------------------------
   // Channels
   // ---------------------------------------------------------------

   // returns at the edge where the transfer happens
   task send_byte(input logic [7:0] b, input logic e, input int unsigned gap_pct);
      if ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < gap_pct);
      end
      req_valid         <= 1'b1;
      req_in_byte       <= b;
      req_end_of_string <= e;
      do @(posedge clock); while (req_stall);
   endtask

   task report_mismatch(input string what, input logic [7:0] got_v,
                        input logic [7:0] want_v);
      // keep the log short when things go badly wrong
      if (errors < 50)
         $display("mismatch on %s: got 0x%02h, expected 0x%02h", what, got_v, want_v);
      errors++;
   endtask

   // long receiver hold-off, counted on its own
   always @(posedge clock) begin
      if (pace == MODE_PRESSURE && hold_cycles < HoldLen)
         hold_cycles <= hold_cycles + 1;
   end

   // result side: check each transfer, then choose next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_out_byte, rsp_byte_valid, rsp_last_of_run, rsp_string_done};
         if (due_bytes.size() == 0) begin
            report_mismatch("result with none expected", got.out_byte, 8'h00);
         end else begin
            want = due_bytes.pop_front();
            if (got.out_byte !== want.out_byte)
               report_mismatch("out_byte", got.out_byte, want.out_byte);
            if (got.byte_valid !== want.byte_valid)
               report_mismatch("byte_valid", 8'(got.byte_valid), 8'(want.byte_valid));
            if (got.last_of_run !== want.last_of_run)
               report_mismatch("last_of_run", 8'(got.last_of_run), 8'(want.last_of_run));
            if (got.string_done !== want.string_done)
               report_mismatch("string_done", 8'(got.string_done), 8'(want.string_done));
         end
      end
      // hold off while the pressure stretch runs, so the block fills and pushes back
      if (pace == MODE_PRESSURE && hold_cycles < HoldLen) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rx_pct[pace]);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------

   initial begin
      jsu_pkg::item_type it;
      clear_decoder();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < 27; i++) begin
         send_byte(dir_tab[i].in_byte, dir_tab[i].eos, tx_pct[MODE_SLOW_RX]);
         unescape_byte(dir_tab[i].in_byte, dir_tab[i].eos);
         if (dir_tab[i].typed)
            due_bytes.push_back('{dir_tab[i].want_byte, dir_tab[i].want_valid,
                                  1'b1, dir_tab[i].eos});
         else
            queue_run(dir_tab[i].eos);
      end

      // random phases, one per pacing mode
      for (int m = 0; m < 4; m++) begin
         pace <= pace_type'(m);
         for (int n = 0; n < phase_items[m]; n++) begin
            if (stim_q.size() == 0) add_token();
            it = stim_q.pop_front();
            send_byte(it.in_byte, it.end_of_string, tx_pct[m]);
            unescape_byte(it.in_byte, it.end_of_string);
            queue_run(it.end_of_string);
         end
      end
      req_valid <= 1'b0;

      // drain, then keep watching for anything stray
      while (due_bytes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
